[rtl/csvfp_pkg.sv]
// ----------------------------------------------------------------------------
// CSV frame line parser package
// Request and response types, token phase codes, frame kinds and characters.
// ----------------------------------------------------------------------------
package csvfp_pkg;

   typedef struct packed {
      logic       command;
      logic [7:0] char_byte;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [2:0]  frame_kind;
      logic [31:0] value_0;
      logic [31:0] value_1;
      logic [31:0] value_2;
      logic [31:0] value_3;
      logic [31:0] value_4;
      logic [31:0] value_5;
      logic [31:0] value_6;
   } rsp_type;

   typedef enum logic [5:0] {
      PH_BETWEEN = 6'b000001,
      PH_KIND    = 6'b000010,
      PH_LEADWS  = 6'b000100,
      PH_SIGN    = 6'b001000,
      PH_DIGITS  = 6'b010000,
      PH_DEAD    = 6'b100000
   } phase_type;

   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_EOL  = 1'b1;

   localparam logic [2:0] KIND_T = 3'd0;
   localparam logic [2:0] KIND_D = 3'd1;
   localparam logic [2:0] KIND_H = 3'd2;
   localparam logic [2:0] KIND_A = 3'd3;
   localparam logic [2:0] KIND_S = 3'd4;
   localparam logic [2:0] KIND_P = 3'd5;
   localparam logic [2:0] KIND_R = 3'd6;
   localparam logic [2:0] KIND_B = 3'd7;

   localparam logic [3:0] NEED_T     = 4'd7;
   localparam logic [3:0] NEED_D     = 4'd6;
   localparam logic [3:0] NEED_GROUP = 4'd4;
   localparam logic [3:0] INDEX_MAX  = 4'd15;
   localparam int         NUM_SLOTS  = 7;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_D     = 8'h44;
   localparam logic [7:0] CHAR_H     = 8'h48;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_R     = 8'h52;
   localparam logic [7:0] CHAR_B     = 8'h42;

endpackage

[rtl/csv_frame_line_parser.sv]
// ----------------------------------------------------------------------------
// CSV frame line parser
// Parses one comma separated frame line per end-of-line request.
// ----------------------------------------------------------------------------
// The response is registered: the combinational parse step lies between the
// request register and the response register. Throughput: 1 request per cycle;
// an end-of-line request stalls while a held response waits in its register.
// Reset: synchronous; clears the parse state and both valid flags.
module csv_frame_line_parser #(
   parameter int MAX_LINE = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  csvfp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output csvfp_pkg::rsp_type rsp_data
);

   localparam int LEN_W = $clog2(MAX_LINE + 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LINE);

   logic                 stg_valid_ff, stg_valid_in;
   csvfp_pkg::req_type   stg_req_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   csvfp_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [LEN_W-1:0]     len_ff, len_in;
   logic [3:0]           index_ff, index_in;
   csvfp_pkg::phase_type phase_ff, phase_in;
   logic [2:0]           kind_ff, kind_in;
   logic                 seen_ff, seen_in;
   logic [31:0]          acc_ff, acc_in;
   logic                 err_ff, err_in;
   logic [31:0]          store_ff [csvfp_pkg::NUM_SLOTS];
   logic [31:0]          store_in [csvfp_pkg::NUM_SLOTS];

   logic        advance;
   logic        is_eol;
   logic [7:0]  ch;
   logic [3:0]  need;
   logic [3:0]  digit;
   logic [35:0] prod;
   logic        is_space, is_digit;
   logic        kind_ok;
   logic [2:0]  kind_dec;
   logic        fin_err, fin_store, slot_ok;
   logic [3:0]  slot_full;
   logic [2:0]  slot;
   logic        eol_ok;
   logic [31:0] val [csvfp_pkg::NUM_SLOTS];

   assign is_eol    = (stg_req_ff.command == csvfp_pkg::CMD_EOL);
   assign advance   = stg_valid_ff && (!is_eol || !rsp_valid_ff || !rsp_stall);
   assign req_stall = stg_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign ch       = stg_req_ff.char_byte;
   assign digit    = 4'(ch - csvfp_pkg::CHAR_ZERO);
   assign is_digit = (ch inside {[csvfp_pkg::CHAR_ZERO:csvfp_pkg::CHAR_NINE]});
   assign is_space = (ch inside {[csvfp_pkg::CHAR_TAB:csvfp_pkg::CHAR_CR],
                                 csvfp_pkg::CHAR_SPACE});
   assign prod     = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {32'd0, digit};

   always_comb begin
      case (kind_ff)
         csvfp_pkg::KIND_T: need = csvfp_pkg::NEED_T;
         csvfp_pkg::KIND_D: need = csvfp_pkg::NEED_D;
         default:           need = csvfp_pkg::NEED_GROUP;
      endcase
   end

   always_comb begin
      kind_ok  = 1'b1;
      kind_dec = csvfp_pkg::KIND_T;
      case (ch)
         csvfp_pkg::CHAR_T: kind_dec = csvfp_pkg::KIND_T;
         csvfp_pkg::CHAR_D: kind_dec = csvfp_pkg::KIND_D;
         csvfp_pkg::CHAR_H: kind_dec = csvfp_pkg::KIND_H;
         csvfp_pkg::CHAR_A: kind_dec = csvfp_pkg::KIND_A;
         csvfp_pkg::CHAR_S: kind_dec = csvfp_pkg::KIND_S;
         csvfp_pkg::CHAR_P: kind_dec = csvfp_pkg::KIND_P;
         csvfp_pkg::CHAR_R: kind_dec = csvfp_pkg::KIND_R;
         csvfp_pkg::CHAR_B: kind_dec = csvfp_pkg::KIND_B;
         default:           kind_ok  = 1'b0;
      endcase
   end

   assign fin_err   = (phase_ff == csvfp_pkg::PH_LEADWS) || (phase_ff == csvfp_pkg::PH_SIGN);
   assign fin_store = (phase_ff == csvfp_pkg::PH_DIGITS);
   assign slot_full = index_ff - 4'd2;
   assign slot_ok   = (index_ff >= 4'd2) && (slot_full < 4'(csvfp_pkg::NUM_SLOTS));
   assign slot      = slot_full[2:0];

   always_comb begin
      for (int i = 0; i < csvfp_pkg::NUM_SLOTS; i++) begin
         if (fin_store && slot_ok && (slot == 3'(i))) begin
            val[i] = acc_ff;
         end else begin
            val[i] = store_ff[i];
         end
      end
   end

   assign eol_ok = !err_ff && !fin_err && (len_ff != '0) && (len_ff < LEN_MAX) &&
                   seen_ff && (index_ff >= need + 4'd1);

   always_comb begin
      len_in   = len_ff;
      index_in = index_ff;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      seen_in  = seen_ff;
      acc_in   = acc_ff;
      err_in   = err_ff;
      for (int i = 0; i < csvfp_pkg::NUM_SLOTS; i++) begin
         store_in[i] = store_ff[i];
      end
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (advance && !is_eol) begin
         if (phase_ff != csvfp_pkg::PH_DEAD) begin
            if (ch == csvfp_pkg::CHAR_NUL) begin
               if (fin_err) begin
                  err_in = 1'b1;
               end
               if (fin_store && slot_ok) begin
                  store_in[slot] = acc_ff;
               end
               phase_in = csvfp_pkg::PH_DEAD;
            end else begin
               if (len_ff < LEN_MAX) begin
                  len_in = len_ff + LEN_W'(1);
               end
               if (!err_ff) begin
                  if (ch == csvfp_pkg::CHAR_COMMA) begin
                     if (fin_err) begin
                        err_in = 1'b1;
                     end
                     if (fin_store && slot_ok) begin
                        store_in[slot] = acc_ff;
                     end
                     phase_in = csvfp_pkg::PH_BETWEEN;
                  end else begin
                     case (phase_ff)
                        csvfp_pkg::PH_BETWEEN: begin
                           if (index_ff < csvfp_pkg::INDEX_MAX) begin
                              index_in = index_ff + 4'd1;
                           end
                           if (index_ff == 4'd0) begin
                              if (!kind_ok) begin
                                 err_in = 1'b1;
                              end else begin
                                 kind_in  = kind_dec;
                                 seen_in  = 1'b1;
                                 phase_in = csvfp_pkg::PH_KIND;
                              end
                           end else if (index_ff <= need) begin
                              acc_in   = '0;
                              phase_in = csvfp_pkg::PH_LEADWS;
                              if (is_space) begin
                                 phase_in = csvfp_pkg::PH_LEADWS;
                              end else if (ch == csvfp_pkg::CHAR_PLUS) begin
                                 phase_in = csvfp_pkg::PH_SIGN;
                              end else if (is_digit) begin
                                 acc_in   = {28'd0, digit};
                                 phase_in = csvfp_pkg::PH_DIGITS;
                              end else begin
                                 err_in = 1'b1;
                              end
                           end
                        end
                        csvfp_pkg::PH_KIND: err_in = 1'b1;
                        csvfp_pkg::PH_LEADWS: begin
                           if (is_space) begin
                              phase_in = csvfp_pkg::PH_LEADWS;
                           end else if (ch == csvfp_pkg::CHAR_PLUS) begin
                              phase_in = csvfp_pkg::PH_SIGN;
                           end else if (is_digit) begin
                              acc_in   = {28'd0, digit};
                              phase_in = csvfp_pkg::PH_DIGITS;
                           end else begin
                              err_in = 1'b1;
                           end
                        end
                        csvfp_pkg::PH_SIGN: begin
                           if (is_digit) begin
                              acc_in   = {28'd0, digit};
                              phase_in = csvfp_pkg::PH_DIGITS;
                           end else begin
                              err_in = 1'b1;
                           end
                        end
                        csvfp_pkg::PH_DIGITS: begin
                           if (!is_digit) begin
                              err_in = 1'b1;
                           end else begin
                              acc_in = prod[31:0];
                              if (prod[35:32] != 4'd0) begin
                                 err_in = 1'b1;
                              end
                           end
                        end
                        default: phase_in = phase_ff;
                     endcase
                  end
               end
            end
         end
      end else if (advance && is_eol) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (eol_ok) begin
            rsp_data_in.accepted   = 1'b1;
            rsp_data_in.frame_kind = kind_ff;
            rsp_data_in.value_0    = val[0];
            rsp_data_in.value_1    = val[1];
            rsp_data_in.value_2    = val[2];
            rsp_data_in.value_3    = val[3];
            if (need > 4'd4) begin
               rsp_data_in.value_4 = val[4];
               rsp_data_in.value_5 = val[5];
            end
            if (need > 4'd6) begin
               rsp_data_in.value_6 = val[6];
            end
            case (kind_ff)
               csvfp_pkg::KIND_T: begin
                  rsp_data_in.value_5 = {24'd0, val[5][7:0]};
               end
               csvfp_pkg::KIND_D: begin
                  rsp_data_in.value_0 = {16'd0, val[0][15:0]};
                  rsp_data_in.value_1 = {24'd0, val[1][7:0]};
                  rsp_data_in.value_4 = {24'd0, val[4][7:0]};
               end
               default: begin
                  rsp_data_in.value_0 = {24'd0, val[0][7:0]};
                  rsp_data_in.value_3 = {16'd0, val[3][15:0]};
               end
            endcase
         end
         len_in   = '0;
         index_in = '0;
         phase_in = csvfp_pkg::PH_BETWEEN;
         kind_in  = csvfp_pkg::KIND_T;
         seen_in  = 1'b0;
         acc_in   = '0;
         err_in   = 1'b0;
         for (int i = 0; i < csvfp_pkg::NUM_SLOTS; i++) begin
            store_in[i] = '0;
         end
      end
   end

   assign stg_valid_in = req_valid || (stg_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
         index_ff     <= '0;
         phase_ff     <= csvfp_pkg::PH_BETWEEN;
         kind_ff      <= csvfp_pkg::KIND_T;
         seen_ff      <= 1'b0;
         acc_ff       <= '0;
         err_ff       <= 1'b0;
         for (int i = 0; i < csvfp_pkg::NUM_SLOTS; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         index_ff     <= index_in;
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         seen_ff      <= seen_in;
         acc_ff       <= acc_in;
         err_ff       <= err_in;
         for (int i = 0; i < csvfp_pkg::NUM_SLOTS; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         stg_req_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// CSV frame line parser testbench
// Streams text lines into the parser one byte per request, then an end-of-line
// request. It predicts the parse of every line and checks each response field
// by field. Random gaps on the request side and stalls on the response side
// run throughout. One long response hold-off fills the parser.
// ----------------------------------------------------------------------------
module testbench;

   localparam int          LINE_MAX     = 128;
   localparam int          RANDOM_ITEMS = 1900;
   localparam int          MIN_LINES    = 60;
   localparam int          HOLD_CYCLES  = 250;
   localparam int          QUIET_LIMIT  = 2000;
   localparam int          DRAIN_CYCLES = 10;
   localparam logic [7:0]  CHAR_MINUS   = 8'h2D;
   localparam logic [7:0]  CHAR_FILL    = 8'h78;

   class frame_scoreboard;
      csvfp_pkg::rsp_type   pending_frames[$];
      int unsigned          mismatches;
      int unsigned          line_len;
      int unsigned          token_count;
      csvfp_pkg::phase_type phase;
      logic [2:0]           kind;
      bit                   kind_known;
      longint unsigned      acc;
      bit                   bad;
      logic [31:0]          slots [csvfp_pkg::NUM_SLOTS];

      function new();
         mismatches = 0;
         clear_line();
      endfunction

      function void clear_line();
         line_len    = 0;
         token_count = 0;
         phase       = csvfp_pkg::PH_BETWEEN;
         kind        = csvfp_pkg::KIND_T;
         kind_known  = 1'b0;
         acc         = 0;
         bad         = 1'b0;
         foreach (slots[i]) slots[i] = '0;
      endfunction

      function int unsigned need_of(logic [2:0] k);
         case (k)
            csvfp_pkg::KIND_T: return csvfp_pkg::NEED_T;
            csvfp_pkg::KIND_D: return csvfp_pkg::NEED_D;
            default:           return csvfp_pkg::NEED_GROUP;
         endcase
      endfunction

      function int kind_code(logic [7:0] c);
         case (c)
            csvfp_pkg::CHAR_T: return csvfp_pkg::KIND_T;
            csvfp_pkg::CHAR_D: return csvfp_pkg::KIND_D;
            csvfp_pkg::CHAR_H: return csvfp_pkg::KIND_H;
            csvfp_pkg::CHAR_A: return csvfp_pkg::KIND_A;
            csvfp_pkg::CHAR_S: return csvfp_pkg::KIND_S;
            csvfp_pkg::CHAR_P: return csvfp_pkg::KIND_P;
            csvfp_pkg::CHAR_R: return csvfp_pkg::KIND_R;
            csvfp_pkg::CHAR_B: return csvfp_pkg::KIND_B;
            default:           return -1;
         endcase
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == csvfp_pkg::CHAR_SPACE ||
                (c >= csvfp_pkg::CHAR_TAB && c <= csvfp_pkg::CHAR_CR);
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= csvfp_pkg::CHAR_ZERO && c <= csvfp_pkg::CHAR_NINE;
      endfunction

      function void close_token();
         if (phase == csvfp_pkg::PH_LEADWS || phase == csvfp_pkg::PH_SIGN) begin
            bad = 1'b1;
         end else if (phase == csvfp_pkg::PH_DIGITS &&
                      token_count - 2 < csvfp_pkg::NUM_SLOTS) begin
            slots[token_count - 2] = acc[31:0];
         end
         if (phase != csvfp_pkg::PH_DEAD) phase = csvfp_pkg::PH_BETWEEN;
      endfunction

      function void lead_char(logic [7:0] c);
         if (is_blank(c)) return;
         if (c == csvfp_pkg::CHAR_PLUS) begin
            phase = csvfp_pkg::PH_SIGN;
         end else if (is_digit(c)) begin
            acc   = c - csvfp_pkg::CHAR_ZERO;
            phase = csvfp_pkg::PH_DIGITS;
         end else begin
            bad = 1'b1;
         end
      endfunction

      function void open_token(logic [7:0] c);
         int unsigned idx;
         int          code;
         idx = token_count;
         if (token_count < csvfp_pkg::INDEX_MAX) token_count++;
         if (idx == 0) begin
            code = kind_code(c);
            if (code < 0) begin
               bad = 1'b1;
               return;
            end
            kind       = code[2:0];
            kind_known = 1'b1;
            phase      = csvfp_pkg::PH_KIND;
            return;
         end
         if (idx > need_of(kind)) return;
         acc   = 0;
         phase = csvfp_pkg::PH_LEADWS;
         lead_char(c);
      endfunction

      function void take_char(logic [7:0] c);
         if (phase == csvfp_pkg::PH_DEAD) return;
         if (c == csvfp_pkg::CHAR_NUL) begin
            close_token();
            phase = csvfp_pkg::PH_DEAD;
            return;
         end
         if (line_len < LINE_MAX) line_len++;
         if (bad) return;
         if (c == csvfp_pkg::CHAR_COMMA) begin
            close_token();
            return;
         end
         case (phase)
            csvfp_pkg::PH_BETWEEN: open_token(c);
            csvfp_pkg::PH_KIND:    bad = 1'b1;
            csvfp_pkg::PH_LEADWS:  lead_char(c);
            csvfp_pkg::PH_SIGN: begin
               if (is_digit(c)) begin
                  acc   = c - csvfp_pkg::CHAR_ZERO;
                  phase = csvfp_pkg::PH_DIGITS;
               end else begin
                  bad = 1'b1;
               end
            end
            csvfp_pkg::PH_DIGITS: begin
               if (!is_digit(c)) begin
                  bad = 1'b1;
               end else begin
                  acc = acc * 10 + (c - csvfp_pkg::CHAR_ZERO);
                  if (acc > 64'hFFFF_FFFF) bad = 1'b1;
               end
            end
            default: ;
         endcase
      endfunction

      function csvfp_pkg::rsp_type end_line();
         csvfp_pkg::rsp_type frame;
         logic [31:0]        v [csvfp_pkg::NUM_SLOTS];
         int unsigned        need;
         if (!bad) close_token();
         need  = need_of(kind);
         frame = '0;
         if (!bad && line_len > 0 && line_len < LINE_MAX && kind_known &&
             token_count >= need + 1) begin
            foreach (v[i]) v[i] = (i < need) ? slots[i] : 32'd0;
            case (kind)
               csvfp_pkg::KIND_T: v[5] &= 32'hFF;
               csvfp_pkg::KIND_D: begin
                  v[0] &= 32'hFFFF;
                  v[1] &= 32'hFF;
                  v[4] &= 32'hFF;
               end
               default: begin
                  v[0] &= 32'hFF;
                  v[3] &= 32'hFFFF;
               end
            endcase
            frame.accepted   = 1'b1;
            frame.frame_kind = kind;
            frame.value_0    = v[0];
            frame.value_1    = v[1];
            frame.value_2    = v[2];
            frame.value_3    = v[3];
            frame.value_4    = v[4];
            frame.value_5    = v[5];
            frame.value_6    = v[6];
         end
         clear_line();
         return frame;
      endfunction

      function void note_request(csvfp_pkg::req_type item);
         if (item.command == csvfp_pkg::CMD_DATA) take_char(item.char_byte);
         else pending_frames.push_back(end_line());
      endfunction

      task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
         mismatches++;
         if (mismatches <= 40)
            $display("mismatch in %s: got %0h, expected %0h", field, got, want);
      endtask

      task check_response(csvfp_pkg::rsp_type got);
         csvfp_pkg::rsp_type want;
         if (pending_frames.size() == 0) begin
            report_mismatch("unexpected response", 32'd0, 32'd0);
            return;
         end
         want = pending_frames.pop_front();
         if (got.accepted !== want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
         if (got.frame_kind !== want.frame_kind)
            report_mismatch("frame_kind", got.frame_kind, want.frame_kind);
         if (got.value_0 !== want.value_0) report_mismatch("value_0", got.value_0, want.value_0);
         if (got.value_1 !== want.value_1) report_mismatch("value_1", got.value_1, want.value_1);
         if (got.value_2 !== want.value_2) report_mismatch("value_2", got.value_2, want.value_2);
         if (got.value_3 !== want.value_3) report_mismatch("value_3", got.value_3, want.value_3);
         if (got.value_4 !== want.value_4) report_mismatch("value_4", got.value_4, want.value_4);
         if (got.value_5 !== want.value_5) report_mismatch("value_5", got.value_5, want.value_5);
         if (got.value_6 !== want.value_6) report_mismatch("value_6", got.value_6, want.value_6);
      endtask
   endclass

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   csvfp_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   csvfp_pkg::rsp_type rsp_data;

   frame_scoreboard frames;

   logic [7:0]  line_buf[$];
   logic [7:0]  blank_chars [6] = '{csvfp_pkg::CHAR_SPACE, csvfp_pkg::CHAR_TAB, 8'h0A,
                                    8'h0B, 8'h0C, csvfp_pkg::CHAR_CR};
   logic [7:0]  kind_chars [8]  = '{csvfp_pkg::CHAR_T, csvfp_pkg::CHAR_D,
                                    csvfp_pkg::CHAR_H, csvfp_pkg::CHAR_A,
                                    csvfp_pkg::CHAR_S, csvfp_pkg::CHAR_P,
                                    csvfp_pkg::CHAR_R, csvfp_pkg::CHAR_B};
   int unsigned requests_sent = 0;
   int unsigned lines_sent    = 0;
   int unsigned burst_left    = 0;

   csv_frame_line_parser #(.MAX_LINE(LINE_MAX)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   function automatic void add_number(longint unsigned v);
      logic [7:0] digits[$];
      do begin
         digits.push_front(csvfp_pkg::CHAR_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (digits[i]) line_buf.push_back(digits[i]);
   endfunction

   function automatic void pad_to(int n);
      while (line_buf.size() < n) line_buf.push_back(CHAR_FILL);
   endfunction

   task automatic drive_request(input csvfp_pkg::req_type item);
      if (burst_left == 0) begin
         if ($urandom_range(0, 5) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      frames.note_request(item);
      requests_sent++;
   endtask

   task automatic send_line();
      csvfp_pkg::req_type item;
      foreach (line_buf[i]) begin
         item.command   = csvfp_pkg::CMD_DATA;
         item.char_byte = line_buf[i];
         drive_request(item);
      end
      item.command   = csvfp_pkg::CMD_EOL;
      item.char_byte = 8'($urandom_range(0, 255));
      drive_request(item);
      line_buf.delete();
      lines_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) frames.check_response(rsp_data);
   end

   initial begin : response_stall
      bit          held_off;
      int unsigned mode;
      held_off = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && requests_sent >= 600) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(5, 60)) begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      int unsigned     kind_pick;
      int unsigned     count;
      int unsigned     pick;
      int unsigned     pos;
      longint unsigned number;

      frames = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      add_text("T,1,2,3,4,5,300,4294967295");
      send_line();
      add_text("D,70000,300,5,4294967295,700,8");
      send_line();
      add_text("H,300,0,0,70000");
      send_line();
      add_text(",,A,,,1,2,,3,4,extra,-9");
      send_line();
      add_text("S,+0007,+1,2,3");
      send_line();
      add_text("P,");
      foreach (blank_chars[i]) line_buf.push_back(blank_chars[i]);
      add_text("+12,5,6,7");
      send_line();
      add_text("R,1,2,3,4");
      line_buf.push_back(csvfp_pkg::CHAR_NUL);
      add_text("zz-");
      send_line();
      add_text("B,1,2");
      line_buf.push_back(csvfp_pkg::CHAR_NUL);
      add_text(",3,4");
      send_line();
      line_buf.push_back(csvfp_pkg::CHAR_NUL);
      add_text("H,1,2,3,4");
      send_line();
      send_line();
      add_text(",,,");
      send_line();
      add_text("X,1,2,3,4");
      send_line();
      add_text("HH,1,2,3,4");
      send_line();
      add_text("A ,1,2,3,4");
      send_line();
      add_text("H,1,2,3");
      send_line();
      add_text("T,1,2,3,4,5,6");
      send_line();
      add_text("H,-1,2,3,4");
      send_line();
      add_text("H,4294967296,1,2,3");
      send_line();
      add_text("H,1a,2,3,4");
      send_line();
      add_text("H, ,1,2,3");
      send_line();
      add_text("H,+,1,2,3");
      send_line();
      add_text("H,1 ,2,3,4");
      send_line();
      add_text("H,1,2,3,4,");
      pad_to(LINE_MAX - 1);
      send_line();
      add_text("H,1,2,3,4,");
      pad_to(LINE_MAX);
      send_line();
      add_text("D,1,2,3,4,5,6,");
      pad_to(200);
      send_line();

      while (requests_sent < RANDOM_ITEMS || lines_sent < MIN_LINES) begin
         kind_pick = $urandom_range(0, 7);
         count = (kind_pick == csvfp_pkg::KIND_T) ? csvfp_pkg::NEED_T :
                 (kind_pick == csvfp_pkg::KIND_D) ? csvfp_pkg::NEED_D :
                                                    csvfp_pkg::NEED_GROUP;
         if ($urandom_range(0, 3) == 0) count += $urandom_range(1, 3);
         if ($urandom_range(0, 9) == 0) line_buf.push_back(csvfp_pkg::CHAR_COMMA);
         line_buf.push_back(kind_chars[kind_pick]);
         repeat (count) begin
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 1)
               line_buf.push_back(csvfp_pkg::CHAR_COMMA);
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 2)) line_buf.push_back(blank_chars[$urandom_range(0, 5)]);
            if ($urandom_range(0, 4) == 0) line_buf.push_back(csvfp_pkg::CHAR_PLUS);
            if ($urandom_range(0, 5) == 0) line_buf.push_back(csvfp_pkg::CHAR_ZERO);
            pick = $urandom_range(0, 63);
            if (pick == 0) number = 64'hFFFF_FFFF;
            else if (pick == 1) number = 64'h1_0000_0000 + $urandom_range(0, 999);
            else if (pick == 2) number = 64'($urandom) * $urandom_range(2, 50000);
            else if (pick < 12) number = $urandom_range(0, 9);
            else if (pick < 30) number = $urandom_range(0, 65535);
            else number = $urandom;
            add_number(number);
         end
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) line_buf.push_back(csvfp_pkg::CHAR_COMMA);

         pos = $urandom_range(0, line_buf.size() - 1);
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 5))
               0: line_buf[pos] = 8'($urandom_range(1, 255));
               1: line_buf.insert(pos, CHAR_MINUS);
               2: while (line_buf.size() > pos) void'(line_buf.pop_back());
               3: line_buf.insert(pos, csvfp_pkg::CHAR_NUL);
               4: repeat (int'(LINE_MAX + $urandom_range(0, 40)) - int'(line_buf.size()))
                     line_buf.push_back(8'($urandom_range(1, 255)));
               default: line_buf.insert(pos, csvfp_pkg::CHAR_SPACE);
            endcase
         end else if ($urandom_range(0, 9) == 0) begin
            line_buf.delete();
            repeat ($urandom_range(0, 40)) line_buf.push_back(8'($urandom_range(1, 255)));
         end
         send_line();
      end

      req_valid <= 1'b0;
      while (frames.pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frames.mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule

[files.f]
rtl/csvfp_pkg.sv
rtl/csv_frame_line_parser.sv
tb/testbench.sv
